[rtl/wlda_pkg.sv]
// ----------------------------------------------------------------------------
// wlda_pkg
// Shared types, constants and the log2 segment table of the weighted log
// distance accumulator.
// ----------------------------------------------------------------------------
package wlda_pkg;

    // item kind carried in s_tuser
    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_SAMPLE = 1'b1
    } wlda_action_t;

    // per-stage control that rides along with each request
    typedef struct packed {
        logic valid;
        logic hit;   // table index in range, term counts
        logic last;
    } wlda_ctl_t;

    localparam int unsigned PROTO_W  = 32;
    localparam int unsigned WEIGHT_W = 16;
    localparam int unsigned ENTRY_W  = PROTO_W + WEIGHT_W;
    localparam int unsigned SUM_W    = 48;
    localparam int unsigned LOG_W    = 21;   // q5.16 log2 and ln
    localparam int unsigned TERM_W   = 21;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [15:0]      LN2_Q16 = 16'd45426;

    // round(65536 * log2(1 + i/32)), i = 0..32
    function automatic logic [16:0] log2_seg(input logic [5:0] idx);
        logic [16:0] val;
        case (idx)
            6'd0:  val = 17'd0;
            6'd1:  val = 17'd2909;
            6'd2:  val = 17'd5732;
            6'd3:  val = 17'd8473;
            6'd4:  val = 17'd11136;
            6'd5:  val = 17'd13727;
            6'd6:  val = 17'd16248;
            6'd7:  val = 17'd18704;
            6'd8:  val = 17'd21098;
            6'd9:  val = 17'd23433;
            6'd10: val = 17'd25711;
            6'd11: val = 17'd27936;
            6'd12: val = 17'd30109;
            6'd13: val = 17'd32234;
            6'd14: val = 17'd34312;
            6'd15: val = 17'd36346;
            6'd16: val = 17'd38336;
            6'd17: val = 17'd40286;
            6'd18: val = 17'd42196;
            6'd19: val = 17'd44068;
            6'd20: val = 17'd45904;
            6'd21: val = 17'd47705;
            6'd22: val = 17'd49472;
            6'd23: val = 17'd51207;
            6'd24: val = 17'd52911;
            6'd25: val = 17'd54584;
            6'd26: val = 17'd56229;
            6'd27: val = 17'd57845;
            6'd28: val = 17'd59434;
            6'd29: val = 17'd60997;
            6'd30: val = 17'd62534;
            6'd31: val = 17'd64047;
            6'd32: val = 17'd65536;
            default: val = 17'd0;
        endcase
        return val;
    endfunction

endpackage

[rtl/wlda_ram.sv]
// ----------------------------------------------------------------------------
// wlda_ram
// Generic single-clock ram, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module wlda_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/weighted_log_distance_accumulator.sv]
// ----------------------------------------------------------------------------
// weighted_log_distance_accumulator
// path: a sample's term passes stages s0 through s8 before it enters the sum; the
//   distance of a last sample goes to the output register together with its term
// throughput: one request per cycle; input stalls only while a distance waits
//   in the output register and the next one is ready to leave the pipeline
// reset: clears the pipeline control, the sum, the overflow flag and the output valid;
//   the table ram is not cleared and must be loaded before it is sampled
// ----------------------------------------------------------------------------
module weighted_log_distance_accumulator
    import wlda_pkg::*;
#(
    parameter int unsigned MAX_ATTRS    = 64,
    parameter int unsigned MAX_CLUSTERS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // attr_index[5:0], cluster_id[9:6], attr_value[41:10], weight_value[57:42], zero
    input  logic [63:0] s_tdata,
    // action
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,   // last_attr

    output logic        m_tvalid,
    input  logic        m_tready,
    // distance[47:0]
    output logic [47:0] m_tdata,
    // saturated
    output logic [0:0]  m_tuser
);

    localparam int unsigned DEPTH  = MAX_ATTRS * MAX_CLUSTERS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NSTG   = 9;   // request register through term register

    // ------------------------------------------------------------------
    // input unpacking
    // ------------------------------------------------------------------
    logic [5:0]          in_attr;
    logic [3:0]          in_clus;
    logic [31:0]         in_value;
    logic [15:0]         in_weight;
    wlda_action_t        in_action;
    logic                in_ok;
    logic [ADDR_W-1:0]   in_addr;
    logic                accept;
    logic                adv;

    assign in_attr   = s_tdata[5:0];
    assign in_clus   = s_tdata[9:6];
    assign in_value  = s_tdata[41:10];
    assign in_weight = s_tdata[57:42];
    assign in_action = wlda_action_t'(s_tuser[0]);

    // entry = attr * clusters + cluster, only when both are in range
    assign in_ok   = (32'(in_attr) < 32'(MAX_ATTRS)) && (32'(in_clus) < 32'(MAX_CLUSTERS));
    assign in_addr = ADDR_W'(32'(in_attr) * 32'(MAX_CLUSTERS) + 32'(in_clus));

    assign accept   = s_tvalid && s_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // table ram: {weight, prototype}; loads write at request time, samples
    // read at request time, so a sample always sees every earlier load
    // ------------------------------------------------------------------
    logic                ram_we;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;

    assign ram_we = accept && (in_action == ACT_LOAD) && in_ok;
    assign ram_re = accept && (in_action == ACT_SAMPLE);

    wlda_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_addr),
        .wdata ({in_weight, in_value}),
        .re    (ram_re),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // control pipeline: one entry per stage, valid bits cleared on reset
    // ------------------------------------------------------------------
    wlda_ctl_t ctl_reg  [NSTG];
    wlda_ctl_t ctl_next [NSTG];

    always_comb begin
        ctl_next[0].valid = ram_re;
        ctl_next[0].hit   = in_ok;
        ctl_next[0].last  = s_tlast;
        for (int i = 1; i < NSTG; i++) begin
            ctl_next[i] = ctl_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // datapath stages
    // ------------------------------------------------------------------
    // s0: sample value waits for the ram read
    logic [31:0]         s0_value_reg,  s0_value_next;
    // s1: |x - p| and weight
    logic [31:0]         s1_mag_reg,    s1_mag_next;
    logic [15:0]         s1_w_reg,      s1_w_next;
    // s2: square, q32.32
    logic [63:0]         s2_sq_reg,     s2_sq_next;
    logic [15:0]         s2_w_reg;
    // s3: v = 1 + square
    logic [63:0]         s3_v_reg,      s3_v_next;
    logic [15:0]         s3_w_reg;
    // s4: leading-one position above bit 32, upper bits of v
    logic [4:0]          s4_e_reg,      s4_e_next;
    logic [47:0]         s4_vtop_reg;
    logic [15:0]         s4_w_reg;
    // s5: 16 bits below the leading one
    logic [15:0]         s5_f_reg,      s5_f_next;
    logic [4:0]          s5_e_reg;
    logic [15:0]         s5_w_reg;
    // s6: log2 in q5.16
    logic [LOG_W-1:0]    s6_l2_reg,     s6_l2_next;
    logic [15:0]         s6_w_reg;
    // s7: ln in q5.16
    logic [LOG_W-1:0]    s7_ln_reg,     s7_ln_next;
    logic [15:0]         s7_w_reg;
    // s8: weighted term
    logic [TERM_W-1:0]   s8_term_reg,   s8_term_next;

    logic signed [32:0]  diff;
    logic [5:0]          seg_lo;
    logic [5:0]          seg_hi;
    logic [16:0]         tab_lo;
    logic [16:0]         tab_hi;
    logic [16:0]         tab_delta;
    logic [27:0]         interp_prod;
    logic [36:0]         ln_prod;
    logic [36:0]         term_prod;

    assign s0_value_next = in_value;

    // exact difference; its magnitude always fits 32 bits
    assign diff        = $signed({s0_value_reg[31], s0_value_reg})
                       - $signed({ram_rdata[31], ram_rdata[31:0]});
    assign s1_mag_next = diff[32] ? 32'(-diff) : diff[31:0];
    assign s1_w_next   = ram_rdata[47:32];

    assign s2_sq_next = s1_mag_reg * s1_mag_reg;

    // never wraps: square <= (2^32-1)^2
    assign s3_v_next = s2_sq_reg + 64'h0000_0001_0000_0000;

    // leading-one search over the upper word, which is never zero
    always_comb begin
        s4_e_next = '0;
        for (int i = 0; i < 32; i++) begin
            if (s3_v_reg[32+i]) begin
                s4_e_next = 5'(i);
            end
        end
    end

    // bits just below the leading one: v >> (e + 16)
    assign s5_f_next = 16'(s4_vtop_reg >> s4_e_reg);

    // segment lookup with linear interpolation on the low 11 bits
    assign seg_lo      = {1'b0, s5_f_reg[15:11]};
    assign seg_hi      = seg_lo + 6'd1;
    assign tab_lo      = log2_seg(seg_lo);
    assign tab_hi      = log2_seg(seg_hi);
    assign tab_delta   = tab_hi - tab_lo;
    assign interp_prod = 28'(tab_delta) * 28'(s5_f_reg[10:0]);
    assign s6_l2_next  = LOG_W'({s5_e_reg, 16'd0})
                       + LOG_W'(tab_lo)
                       + LOG_W'(interp_prod >> 11);

    // ln = log2 * ln2, truncated
    assign ln_prod    = 37'(s6_l2_reg) * 37'(LN2_Q16);
    assign s7_ln_next = LOG_W'(ln_prod >> 16);

    // term = weight * ln, truncated
    assign term_prod    = 37'(s7_w_reg) * 37'(s7_ln_reg);
    assign s8_term_next = TERM_W'(term_prod >> 16);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_value_reg <= s0_value_next;
            s1_mag_reg   <= s1_mag_next;
            s1_w_reg     <= s1_w_next;
            s2_sq_reg    <= s2_sq_next;
            s2_w_reg     <= s1_w_reg;
            s3_v_reg     <= s3_v_next;
            s3_w_reg     <= s2_w_reg;
            s4_e_reg     <= s4_e_next;
            s4_vtop_reg  <= s3_v_reg[63:16];
            s4_w_reg     <= s3_w_reg;
            s5_f_reg     <= s5_f_next;
            s5_e_reg     <= s4_e_reg;
            s5_w_reg     <= s4_w_reg;
            s6_l2_reg    <= s6_l2_next;
            s6_w_reg     <= s5_w_reg;
            s7_ln_reg    <= s7_ln_next;
            s7_w_reg     <= s6_w_reg;
            s8_term_reg  <= s8_term_next;
        end
    end

    // ------------------------------------------------------------------
    // accumulator with saturation, and the output register
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]    sum_reg,   sum_next;
    logic                ovf_reg,   ovf_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [SUM_W-1:0]    m_tdata_reg,  m_tdata_next;
    logic                m_tuser_reg,  m_tuser_next;
    logic [SUM_W:0]      sum_ext;
    logic [SUM_W-1:0]    sum_upd;
    logic                ovf_upd;
    logic                emit;

    // only a last sample at the end of the pipe needs the output register
    assign adv  = !(ctl_reg[NSTG-1].valid && ctl_reg[NSTG-1].last
                    && m_tvalid_reg && !m_tready);
    assign emit = adv && ctl_reg[NSTG-1].valid && ctl_reg[NSTG-1].last;

    assign sum_ext = {1'b0, sum_reg} + (SUM_W+1)'(s8_term_reg);

    always_comb begin
        sum_upd = sum_reg;
        ovf_upd = ovf_reg;
        if (ctl_reg[NSTG-1].valid && ctl_reg[NSTG-1].hit) begin
            // reaching the top counts as saturation
            if (sum_ext >= {1'b0, SUM_MAX}) begin
                sum_upd = SUM_MAX;
                ovf_upd = 1'b1;
            end else begin
                sum_upd = sum_ext[SUM_W-1:0];
            end
        end
    end

    always_comb begin
        sum_next      = sum_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (adv) begin
            sum_next = sum_upd;
            ovf_next = ovf_upd;
        end
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = sum_upd;
            m_tuser_next  = ovf_upd;
            sum_next      = '0;
            ovf_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg      <= '{default: '0};
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (adv) begin
                ctl_reg <= ctl_next;
            end
            sum_reg      <= sum_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a last sample leaving the pipe always lands in the output register
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid_reg)
        else $error("distance not presented after emission");

    // the sum can only sit at its maximum with the overflow flag set
    a_sat_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        !ovf_reg |-> (sum_reg != SUM_MAX))
        else $error("sum at maximum without overflow flag");

    // the input side stalls only behind a distance that is held off
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid_reg && !m_tready))
        else $error("input stalled without output backpressure");

    // the sum is zero right after a distance leaves the pipe
    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (sum_reg == '0) && !ovf_reg)
        else $error("sum not cleared after emission");

endmodule

[dv/tb_weighted_log_distance_accumulator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighted_log_distance_accumulator
// Streams table loads and attribute samples into the accumulator and checks
// every emitted distance against a cycle-free predictor of the weighted log
// sum, under several patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_weighted_log_distance_accumulator;
    import wlda_pkg::*;

    localparam int unsigned N_ATTRS    = 64;
    localparam int unsigned N_CLUSTERS = 16;
    localparam int unsigned N_ENTRIES  = N_ATTRS * N_CLUSTERS;
    localparam int unsigned STALL_LIMIT = 5000;  // cycles with no request or result moving
    localparam int unsigned TAIL_CYCLES = 30;    // pipeline is 9 deep, some margin on top
    localparam logic [47:0] DIST_MAX = 48'hFFFF_FFFF_FFFF;

    // log2(1 + i/32) in q1.16, rounded
    localparam int unsigned SEG_LOG2 [33] = '{
        0, 2909, 5732, 8473, 11136, 13727, 16248, 18704,
        21098, 23433, 25711, 27936, 30109, 32234, 34312, 36346,
        38336, 40286, 42196, 44068, 45904, 47705, 49472, 51207,
        52911, 54584, 56229, 57845, 59434, 60997, 62534, 64047,
        65536
    };

    typedef struct {
        wlda_action_t act;
        logic [5:0]   attr;
        logic [3:0]   clus;
        logic [31:0]  value;
        logic [15:0]  weight;
        logic         last;
        logic         fixed;     // expected distance typed in below
        logic [47:0]  fix_dist;
        logic         fix_sat;
    } stim_t;

    typedef struct {
        logic [47:0] distance;
        logic        sat;
    } distance_t;

    // directed part: corners of the fields and of the log table
    stim_t directed_rows [18] = '{
        // zero difference gives ln(1) = 0
        '{ACT_LOAD,   6'd0,  4'd0,  32'h0000_0000, 16'hFFFF, 1'b0, 1'b0, 48'd0, 1'b0},
        '{ACT_SAMPLE, 6'd0,  4'd0,  32'h0000_0000, 16'h0000, 1'b1, 1'b1, 48'd0, 1'b0},
        // zero weight kills the largest possible difference
        '{ACT_LOAD,   6'd63, 4'd15, 32'h8000_0000, 16'h0000, 1'b0, 1'b0, 48'd0, 1'b0},
        '{ACT_SAMPLE, 6'd63, 4'd15, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 48'd0, 1'b0},
        // last flag on a load is ignored, no distance may come out
        '{ACT_LOAD,   6'd63, 4'd15, 32'h8000_0000, 16'hFFFF, 1'b1, 1'b0, 48'd0, 1'b0},
        // largest term, then a zero term, then close the point elsewhere
        '{ACT_SAMPLE, 6'd63, 4'd15, 32'h7FFF_FFFF, 16'h0000, 1'b0, 1'b0, 48'd0, 1'b0},
        '{ACT_SAMPLE, 6'd63, 4'd15, 32'h8000_0000, 16'h0000, 1'b0, 1'b0, 48'd0, 1'b0},
        '{ACT_SAMPLE, 6'd0,  4'd0,  32'h7FFF_FFFF, 16'h0000, 1'b1, 1'b0, 48'd0, 1'b0},
        // most negative difference
        '{ACT_LOAD,   6'd5,  4'd9,  32'h7FFF_FFFF, 16'h8000, 1'b0, 1'b0, 48'd0, 1'b0},
        '{ACT_SAMPLE, 6'd5,  4'd9,  32'h8000_0000, 16'h0000, 1'b1, 1'b0, 48'd0, 1'b0},
        // difference of exactly +1.0 and -1.0
        '{ACT_LOAD,   6'd1,  4'd1,  32'h0001_0000, 16'hFFFF, 1'b0, 1'b0, 48'd0, 1'b0},
        '{ACT_SAMPLE, 6'd1,  4'd1,  32'h0002_0000, 16'h0000, 1'b1, 1'b0, 48'd0, 1'b0},
        '{ACT_SAMPLE, 6'd1,  4'd1,  32'h0000_0000, 16'h0000, 1'b1, 1'b0, 48'd0, 1'b0},
        // one lsb of difference squares to a single q32.32 lsb, below the bits the log uses
        '{ACT_SAMPLE, 6'd1,  4'd1,  32'h0001_0001, 16'h0000, 1'b1, 1'b1, 48'd0, 1'b0},
        // multi attribute point, weight field on a sample is don't care
        '{ACT_SAMPLE, 6'd0,  4'd0,  32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0, 48'd0, 1'b0},
        '{ACT_SAMPLE, 6'd5,  4'd9,  32'h0000_0000, 16'hABCD, 1'b1, 1'b0, 48'd0, 1'b0},
        // overwrite an entry and use the new contents
        '{ACT_LOAD,   6'd0,  4'd0,  32'hFFFF_0000, 16'h0001, 1'b0, 1'b0, 48'd0, 1'b0},
        '{ACT_SAMPLE, 6'd0,  4'd0,  32'h7FFF_FFFF, 16'h5555, 1'b1, 1'b0, 48'd0, 1'b0}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    weighted_log_distance_accumulator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // predictor state, advanced at each accepted request
    // ------------------------------------------------------------------------
    logic [15:0] weight_mem [N_ENTRIES];
    logic [31:0] proto_mem  [N_ENTRIES];
    logic [47:0] acc_sum = '0;
    logic        acc_ovf = 1'b0;
    distance_t   pending_distances [$];

    // stimulus side view of the table: which entries may be sampled
    logic [31:0] gen_proto [N_ENTRIES];
    bit          gen_loaded [N_ENTRIES];
    int          loaded_addrs [$];

    stim_t cur_stim;        // request currently on the input bus
    int    gap_pct   = 0;   // sender idle chance per cycle
    int    stall_pct = 0;   // receiver stall chance per cycle
    int    err_cnt   = 0;
    int    quiet_cycles = 0;

    // weight * ln(1 + (x - p)^2), all in q.16 with the block's truncations
    function automatic logic [47:0] log_term(logic [31:0] x, logic [31:0] p,
                                             logic [15:0] w);
        longint      xs;
        longint      ps;
        longint      diff;
        logic [63:0] mag;
        logic [63:0] v;
        int          pos;
        logic [15:0] frac;
        int          seg;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] l2;
        logic [63:0] ln_v;
        xs   = $signed(x);
        ps   = $signed(p);
        diff = xs - ps;
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        v    = mag * mag + 64'h1_0000_0000;
        // leading one, never below bit 32 since v >= 1.0
        pos = 63;
        while (pos > 32 && !v[pos])
            pos--;
        frac = 16'(v >> (pos - 16));
        seg  = frac[15:11];
        lo   = SEG_LOG2[seg];
        hi   = SEG_LOG2[seg + 1];
        l2   = (64'(pos - 32) << 16) + lo + (((hi - lo) * frac[10:0]) >> 11);
        ln_v = (l2 * LN2_Q16) >> 16;
        return 48'((64'(w) * ln_v) >> 16);
    endfunction

    task automatic account_request(stim_t r);
        int          addr;
        logic [47:0] term;
        distance_t   d;
        addr = r.attr * N_CLUSTERS + r.clus;
        if (r.act == ACT_LOAD) begin
            weight_mem[addr] = r.weight;
            proto_mem[addr]  = r.value;
        end else begin
            term = log_term(r.value, proto_mem[addr], weight_mem[addr]);
            // saturating add, flag sticks until the distance leaves
            if (term > DIST_MAX - acc_sum) begin
                acc_sum = DIST_MAX;
                acc_ovf = 1'b1;
            end else begin
                acc_sum = acc_sum + term;
                if (acc_sum == DIST_MAX)
                    acc_ovf = 1'b1;
            end
            if (r.last) begin
                d.distance = r.fixed ? r.fix_dist : acc_sum;
                d.sat      = r.fixed ? r.fix_sat : acc_ovf;
                pending_distances.push_back(d);
                acc_sum = '0;
                acc_ovf = 1'b0;
            end
        end
    endtask

    task automatic check_distance(logic [47:0] distance, logic sat);
        distance_t d;
        if (pending_distances.size() == 0) begin
            $display("%0t: unexpected distance, expected none actual %0d sat %0d",
                     $time, distance, sat);
            err_cnt++;
        end else begin
            d = pending_distances.pop_front();
            if (distance !== d.distance) begin
                $display("%0t: distance mismatch, expected %0d actual %0d",
                         $time, d.distance, distance);
                err_cnt++;
            end
            if (sat !== d.sat) begin
                $display("%0t: saturated mismatch, expected %0d actual %0d",
                         $time, d.sat, sat);
                err_cnt++;
            end
        end
    endtask

    // monitor: results are checked before the same edge's request is modeled
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_distance(m_tdata, m_tuser[0]);
            if (s_tvalid && s_tready)
                account_request(cur_stim);
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles where neither side moves
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, %0d distances outstanding",
                         $time, pending_distances.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------
    task automatic send_request(stim_t r);
        int addr;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, r.weight, r.value, r.clus, r.attr};
        s_tuser  <= r.act;
        s_tlast  <= r.last;
        cur_stim <= r;
        do
            @(posedge aclk);
        while (!s_tready);
        // entries become eligible for sampling once their load is issued
        if (r.act == ACT_LOAD) begin
            addr = r.attr * N_CLUSTERS + r.clus;
            gen_proto[addr] = r.value;
            if (!gen_loaded[addr]) begin
                gen_loaded[addr] = 1'b1;
                loaded_addrs.push_back(addr);
            end
        end
    endtask

    // hold the bus idle until every distance in flight has been collected
    task automatic drain_distances();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_distances.size() != 0);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic stim_t make_load(logic last);
        stim_t r;
        r = '{ACT_LOAD, 6'($urandom), 4'($urandom), rand_value(), rand_weight(),
              last, 1'b0, 48'd0, 1'b0};
        return r;
    endfunction

    // sample from a loaded entry, often close to its prototype
    function automatic stim_t make_sample(logic last);
        stim_t       r;
        int          addr;
        logic [31:0] offs;
        addr = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
        offs = $urandom >> $urandom_range(31);
        r.act    = ACT_SAMPLE;
        r.attr   = 6'(addr / N_CLUSTERS);
        r.clus   = 4'(addr % N_CLUSTERS);
        r.value  = $urandom_range(1) ? gen_proto[addr] + ($urandom_range(1) ? offs : -offs)
                                     : rand_value();
        r.weight = 16'($urandom);
        r.last   = last;
        r.fixed  = 1'b0;
        r.fix_dist = '0;
        r.fix_sat  = 1'b0;
        return r;
    endfunction

    task automatic run_phase(int n_items, int gap, int stall);
        int sent;
        int kind;
        int len;
        gap_pct   = gap;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                // burst of table loads
                len = $urandom_range(1, 3);
                repeat (len) send_request(make_load(1'b0));
                sent += len;
            end else if (kind < 20) begin
                // noise: stray last flag on a load, or a lone sample
                if ($urandom_range(1))
                    send_request(make_load(1'b1));
                else
                    send_request(make_sample(1'($urandom)));
                sent++;
            end else begin
                // well formed point, last flag on its final attribute
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_request(make_sample(i == len - 1));
                sent += len;
            end
        end
        drain_distances();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        drain_distances();

        // spread the table before random points start sampling it
        repeat (64) send_request(make_load(1'b0));

        run_phase(380, 0, 0);
        run_phase(370, 77, 0);
        run_phase(370, 0, 77);
        run_phase(370, 38, 38);

        // pipeline may still hold a term after the last distance
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_distances.size() != 0) begin
            $display("%0t: %0d distances never arrived", $time, pending_distances.size());
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/wlda_pkg.sv
rtl/wlda_ram.sv
rtl/weighted_log_distance_accumulator.sv
dv/tb_weighted_log_distance_accumulator.sv
